// ----- rtl/wtv_pkg.sv -----
// ----------------------------------------------------------------------------
// wtv_pkg
// Shared types, constants and tables of the waypoint-to-velocity block.
// ----------------------------------------------------------------------------
package wtv_pkg;

    // Input item: one waypoint.
    typedef struct packed {
        logic signed [19:0] point_x;
        logic signed [19:0] point_y;
        logic signed [15:0] point_heading;
        logic               final_point;
    } t_wp_in;

    // Result item: one motion command.
    typedef struct packed {
        logic               cmd_kind;
        logic        [23:0] forward_speed;
        logic signed [23:0] turn_rate;
        logic               last_of_run;
    } t_cmd_out;

    // Command kinds.
    localparam logic CMD_TURN = 1'b0;
    localparam logic CMD_MOVE = 1'b1;

    // Configuration register indexes.
    localparam logic REG_STEP_TIME = 1'b0;
    localparam logic REG_GOAL      = 1'b1;

    // Divider widths.
    localparam int DIV_NUM_W = 29;
    localparam int DIV_DEN_W = 16;

    // Iteration counts.
    localparam int CORDIC_STEPS = 21;
    localparam int SQRT_STEPS   = 21;

    // Command slots of one waypoint, in output order.
    localparam logic [1:0] SLOT_FACE = 2'd0;
    localparam logic [1:0] SLOT_MOVE = 2'd1;
    localparam logic [1:0] SLOT_HEAD = 2'd2;
    localparam logic [1:0] SLOT_GOAL = 2'd3;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_SQX,
        S_SQY,
        S_SUM,
        S_CHK,
        S_SQRT,
        S_CPRE,
        S_CORD,
        S_PLAN,
        S_NEXT,
        S_DIVW,
        S_OUTW
    } t_state;

    // Request to the shared divider.
    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] dividend;
        logic [DIV_DEN_W-1:0] divisor;
    } t_div_req;

    // atan(2^-i) in units of 2^32 per full turn.
    function automatic logic [31:0] atan_step(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458908;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679839;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/wtv_div.sv -----
// ----------------------------------------------------------------------------
// wtv_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wtv_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  wtv_pkg::t_div_req              i_req,
    output logic [wtv_pkg::DIV_NUM_W-1:0]  o_quotient,
    output logic                           o_done
);

    localparam int NW = wtv_pkg::DIV_NUM_W;
    localparam int DW = wtv_pkg::DIV_DEN_W;

    logic          r_busy;
    logic [4:0]    r_cnt;
    logic [NW-1:0] r_num;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic          r_done;

    logic [DW:0]   trial;
    logic          take;

    // Trial subtraction of one step.
    assign trial = {r_rem, r_num[NW-1]};
    assign take  = trial >= {1'b0, r_den};

    // Control of the iteration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == 5'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 5'd1;
            end
        end
    end

    // Remainder and quotient shift register.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.dividend;
            r_den <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            if (take) begin
                r_rem <= DW'(trial - {1'b0, r_den});
            end else begin
                r_rem <= trial[DW-1:0];
            end
            r_num <= {r_num[NW-2:0], take};
        end
    end

    assign o_quotient = r_num;
    assign o_done     = r_done;

endmodule

// ----- rtl/waypoint_to_velocity_commands.sv -----
// ----------------------------------------------------------------------------
// waypoint_to_velocity_commands
// Turns a path of waypoints into turn and forward-move commands.
//
//   Channel  Signals                                   Direction
//   in       i_in_valid, o_in_ready, i_in_data         waypoint item in
//   out      o_out_valid, i_out_ready, o_out_data      command item out
//   cfg      i_cfg_valid, o_cfg_ready, i_cfg_index,    register write in
//            i_cfg_data
//
// A first waypoint is only recorded and the sequencer stays idle. A later
// waypoint at a new position passes through the squares, the square root,
// the CORDIC and planning; at the previous position it skips the square
// root and the CORDIC. Each command then takes a slot pick, the shared
// divider and an offer on the output, and a last slot pick returns to idle;
// a waypoint gives up to four commands.
// Reset is synchronous and active low; no clearing pass is needed.
// The input is not ready while a waypoint is in work; a stalled output
// holds the sequencer in its output wait.
// ----------------------------------------------------------------------------
module waypoint_to_velocity_commands (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  wtv_pkg::t_wp_in   i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output wtv_pkg::t_cmd_out o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [15:0]       i_cfg_data
);

    wtv_pkg::t_state r_state, n_state;

    logic               r_have;
    logic signed [19:0] r_prev_x, r_prev_y;
    logic [15:0]        r_th;
    logic [15:0]        r_step;
    logic [15:0]        r_goal;
    logic signed [20:0] r_dx, r_dy;
    logic [15:0]        r_ph;
    logic               r_fin;
    logic [41:0]        r_prod;
    logic [41:0]        r_rem;
    logic [41:0]        r_root;
    logic [41:0]        r_bit;
    logic signed [43:0] r_cx, r_cy;
    logic [31:0]        r_cz;
    logic [4:0]         r_cnt;
    logic               r_move;
    logic [3:0]         r_mask;
    logic [15:0]        r_ang [4];
    logic [1:0]         r_slot;
    logic               r_out_valid;
    wtv_pkg::t_cmd_out  r_out;

    logic               in_acc;
    logic               out_acc;
    logic signed [20:0] dx_w, dy_w;
    logic [41:0]        sq_trial;
    logic               sq_ge;
    logic signed [43:0] xs, ys;
    logic               y_pos;
    logic [31:0]        z_rnd;
    logic [15:0]        dir;
    logic [15:0]        a_face, a_head, a_goal;
    logic [1:0]         pick;
    logic [3:0]         pick_bit;
    logic [15:0]        sel_ang;
    logic [16:0]        sel_mag;
    logic [15:0]        divisor;
    wtv_pkg::t_div_req  div_req;
    logic [wtv_pkg::DIV_NUM_W-1:0] div_q;
    logic               div_done;

    assign in_acc      = i_in_valid && o_in_ready;
    assign out_acc     = r_out_valid && i_out_ready;
    assign o_in_ready  = (r_state == wtv_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Position deltas against the previous waypoint.
    assign dx_w = 21'(i_in_data.point_x) - 21'(r_prev_x);
    assign dy_w = 21'(i_in_data.point_y) - 21'(r_prev_y);

    // Square root step.
    assign sq_trial = r_root + r_bit;
    assign sq_ge    = r_rem >= sq_trial;

    // CORDIC step.
    assign xs    = r_cx >>> r_cnt;
    assign ys    = r_cy >>> r_cnt;
    assign y_pos = !r_cy[43] && (r_cy != '0);
    assign z_rnd = r_cz + 32'h8000;
    assign dir   = z_rnd[31:16];

    // Turn angles; each turn leaves the heading at its target.
    assign a_face = dir - r_th;
    assign a_head = r_ph - (r_move ? dir : r_th);
    assign a_goal = r_goal - r_ph;

    // Lowest pending command slot.
    always_comb begin
        if (r_mask[0]) begin
            pick = wtv_pkg::SLOT_FACE;
        end else if (r_mask[1]) begin
            pick = wtv_pkg::SLOT_MOVE;
        end else if (r_mask[2]) begin
            pick = wtv_pkg::SLOT_HEAD;
        end else begin
            pick = wtv_pkg::SLOT_GOAL;
        end
    end

    assign pick_bit = 4'b0001 << r_slot;
    assign sel_ang  = r_ang[pick];
    assign sel_mag  = sel_ang[15] ? 17'(-{sel_ang[15], sel_ang}) : {1'b0, sel_ang};
    assign divisor  = (r_step == '0) ? 16'd1 : r_step;

    // Divider request, started once per command.
    always_comb begin
        div_req.start   = (r_state == wtv_pkg::S_NEXT) && (r_mask != '0);
        div_req.divisor = divisor;
        if (pick == wtv_pkg::SLOT_MOVE) begin
            div_req.dividend = {r_root[20:0], 8'd0};
        end else begin
            div_req.dividend = {4'd0, sel_mag, 8'd0};
        end
    end

    wtv_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .o_quotient (div_q),
        .o_done     (div_done)
    );

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wtv_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            wtv_pkg::S_IDLE: begin
                if (in_acc && r_have) begin
                    n_state = wtv_pkg::S_SQX;
                end
            end
            wtv_pkg::S_SQX: n_state = wtv_pkg::S_SQY;
            wtv_pkg::S_SQY: n_state = wtv_pkg::S_SUM;
            wtv_pkg::S_SUM: n_state = wtv_pkg::S_CHK;
            wtv_pkg::S_CHK: begin
                n_state = (r_rem == '0) ? wtv_pkg::S_PLAN : wtv_pkg::S_SQRT;
            end
            wtv_pkg::S_SQRT: begin
                if (r_cnt == 5'(wtv_pkg::SQRT_STEPS - 1)) begin
                    n_state = wtv_pkg::S_CPRE;
                end
            end
            wtv_pkg::S_CPRE: n_state = wtv_pkg::S_CORD;
            wtv_pkg::S_CORD: begin
                if (r_cnt == 5'(wtv_pkg::CORDIC_STEPS - 1)) begin
                    n_state = wtv_pkg::S_PLAN;
                end
            end
            wtv_pkg::S_PLAN: n_state = wtv_pkg::S_NEXT;
            wtv_pkg::S_NEXT: begin
                n_state = (r_mask == '0) ? wtv_pkg::S_IDLE : wtv_pkg::S_DIVW;
            end
            wtv_pkg::S_DIVW: begin
                if (div_done) begin
                    n_state = wtv_pkg::S_OUTW;
                end
            end
            wtv_pkg::S_OUTW: begin
                if (out_acc) begin
                    n_state = wtv_pkg::S_NEXT;
                end
            end
            default: n_state = wtv_pkg::S_IDLE;
        endcase
    end

    // Control state: path tracking, configuration and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have      <= 1'b0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_th        <= '0;
            r_step      <= 16'd512;
            r_goal      <= '0;
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == wtv_pkg::REG_STEP_TIME) begin
                    r_step <= i_cfg_data;
                end else begin
                    r_goal <= i_cfg_data;
                end
            end
            if (in_acc) begin
                r_prev_x <= i_in_data.point_x;
                r_prev_y <= i_in_data.point_y;
                if (!r_have) begin
                    r_th   <= i_in_data.point_heading;
                    r_have <= !i_in_data.final_point;
                end
            end
            if (r_state == wtv_pkg::S_PLAN) begin
                r_mask <= {r_fin && (a_goal != '0), a_head != '0, r_move,
                           r_move && (a_face != '0)};
                r_th   <= r_fin ? r_goal : r_ph;
                if (r_fin) begin
                    r_have <= 1'b0;
                end
            end
            if ((r_state == wtv_pkg::S_DIVW) && div_done) begin
                r_out_valid <= 1'b1;
                r_mask      <= r_mask & ~pick_bit;
            end
            if (out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath: squares, square root, CORDIC, plan and result building.
    always_ff @(posedge i_clk) begin
        case (r_state)
            wtv_pkg::S_IDLE: begin
                r_dx  <= dx_w;
                r_dy  <= dy_w;
                r_ph  <= i_in_data.point_heading;
                r_fin <= i_in_data.final_point;
            end
            wtv_pkg::S_SQX: begin
                r_prod <= 42'(r_dx * r_dx);
            end
            wtv_pkg::S_SQY: begin
                r_rem  <= r_prod;
                r_prod <= 42'(r_dy * r_dy);
            end
            wtv_pkg::S_SUM: begin
                r_rem <= r_rem + r_prod;
            end
            wtv_pkg::S_CHK: begin
                r_move <= (r_rem != '0);
                r_root <= '0;
                r_bit  <= 42'd1 << 40;
                r_cnt  <= '0;
            end
            wtv_pkg::S_SQRT: begin
                if (sq_ge) begin
                    r_rem  <= r_rem - sq_trial;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 5'd1;
            end
            wtv_pkg::S_CPRE: begin
                // Rotate into the right half plane first.
                if (r_dx[20]) begin
                    r_cx <= -{{3{r_dx[20]}}, r_dx, 20'd0};
                    r_cy <= -{{3{r_dy[20]}}, r_dy, 20'd0};
                    r_cz <= 32'h8000_0000;
                end else begin
                    r_cx <= {{3{r_dx[20]}}, r_dx, 20'd0};
                    r_cy <= {{3{r_dy[20]}}, r_dy, 20'd0};
                    r_cz <= '0;
                end
                r_cnt <= '0;
            end
            wtv_pkg::S_CORD: begin
                if (y_pos) begin
                    r_cx <= r_cx + ys;
                    r_cy <= r_cy - xs;
                    r_cz <= r_cz + wtv_pkg::atan_step(r_cnt);
                end else begin
                    r_cx <= r_cx - ys;
                    r_cy <= r_cy + xs;
                    r_cz <= r_cz - wtv_pkg::atan_step(r_cnt);
                end
                r_cnt <= r_cnt + 5'd1;
            end
            wtv_pkg::S_PLAN: begin
                r_ang[0] <= a_face;
                r_ang[1] <= '0;
                r_ang[2] <= a_head;
                r_ang[3] <= a_goal;
            end
            wtv_pkg::S_NEXT: begin
                r_slot <= pick;
            end
            wtv_pkg::S_DIVW: begin
                if (div_done) begin
                    r_out.last_of_run <= ((r_mask & ~pick_bit) == '0);
                    if (r_slot == wtv_pkg::SLOT_MOVE) begin
                        r_out.cmd_kind  <= wtv_pkg::CMD_MOVE;
                        r_out.turn_rate <= '0;
                        if (div_q[28:24] != '0) begin
                            r_out.forward_speed <= 24'hFF_FFFF;
                        end else begin
                            r_out.forward_speed <= div_q[23:0];
                        end
                    end else begin
                        r_out.cmd_kind      <= wtv_pkg::CMD_TURN;
                        r_out.forward_speed <= '0;
                        if (r_ang[r_slot][15]) begin
                            r_out.turn_rate <= -div_q[23:0];
                        end else begin
                            r_out.turn_rate <= div_q[23:0];
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // The input is only taken with no command pending.
    a_ready_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid)
        else $error("input ready while a command is pending");

    // A command is shown only while the sequencer waits for it.
    a_out_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_state == wtv_pkg::S_OUTW))
        else $error("command valid outside the output wait");

    // The last command of a waypoint leaves nothing pending.
    a_last_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_out_data.last_of_run) |-> (r_mask == '0))
        else $error("commands pending after the last one");

    // The divider finishes only while the sequencer waits on it.
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == wtv_pkg::S_DIVW))
        else $error("divider finished outside its wait");

endmodule

// ----- verif/wtv_checker.sv -----
// ----------------------------------------------------------------------------
// wtv_checker
// Watches the waypoint, command and register channels of the block. It keeps
// its own copy of the path state and the registers, works out the commands
// that each accepted waypoint must give, and compares every accepted command
// field by field with the oldest one still awaited.
// ----------------------------------------------------------------------------
module wtv_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  wtv_pkg::t_wp_in   i_in_data,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  wtv_pkg::t_cmd_out i_out_data,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    output int                o_fail_count,
    output int                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [23:0] SPEED_LIMIT = 24'hFFFFFF;

    // Mirrored registers and path state.
    logic [15:0]        hold_time;
    logic [15:0]        goal_heading;
    logic signed [19:0] last_x;
    logic signed [19:0] last_y;
    logic [15:0]        heading_now;
    logic               path_open;

    wtv_pkg::t_cmd_out cmd_queue[$];
    wtv_pkg::t_cmd_out plan_buf[4];
    int                plan_len;
    int                fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = cmd_queue.size();

    // Floor of the square root, bit by bit.
    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Travel direction as a binary angle by a vectoring CORDIC.
    function automatic logic [15:0] travel_dir(input logic signed [63:0] dx,
                                               input logic signed [63:0] dy);
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] xs;
        logic signed [63:0] ys;
        logic [31:0]        z;
        logic [31:0]        t;
        x = dx * 64'sd1048576;
        y = dy * 64'sd1048576;
        z = 0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        for (int i = 0; i < wtv_pkg::CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z = z + wtv_pkg::atan_step(i[4:0]);
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - wtv_pkg::atan_step(i[4:0]);
            end
        end
        t = z + 32'h8000;
        return t[31:16];
    endfunction

    function automatic logic [63:0] divisor();
        return (hold_time == 0) ? 64'd1 : {48'd0, hold_time};
    endfunction

    // Adds a turn by the wrapped angle unless it is zero.
    task automatic add_turn(input logic [15:0] delta);
        logic signed [63:0] ang;
        logic signed [63:0] rate;
        ang = {{48{delta[15]}}, delta};
        if (ang != 0) begin
            rate = (ang * 64'sd256) / $signed(divisor());
            plan_buf[plan_len].cmd_kind      = wtv_pkg::CMD_TURN;
            plan_buf[plan_len].forward_speed = '0;
            plan_buf[plan_len].turn_rate     = rate[23:0];
            plan_buf[plan_len].last_of_run   = 1'b0;
            plan_len++;
            heading_now = heading_now + delta;
        end
    endtask

    // Works out the commands of one waypoint and queues them.
    task automatic plan_waypoint(input wtv_pkg::t_wp_in w);
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        logic [63:0]        d2;
        logic [63:0]        spd;
        plan_len = 0;
        if (!path_open) begin
            last_x      = w.point_x;
            last_y      = w.point_y;
            heading_now = w.point_heading;
            path_open   = !w.final_point;
        end else begin
            dx = 64'(w.point_x) - 64'(last_x);
            dy = 64'(w.point_y) - 64'(last_y);
            d2 = dx * dx + dy * dy;
            if (d2 != 0) begin
                spd = (root_floor(d2) * 64'd256) / divisor();
                add_turn(travel_dir(dx, dy) - heading_now);
                plan_buf[plan_len].cmd_kind      = wtv_pkg::CMD_MOVE;
                plan_buf[plan_len].forward_speed =
                    (spd > 64'(SPEED_LIMIT)) ? SPEED_LIMIT : spd[23:0];
                plan_buf[plan_len].turn_rate     = '0;
                plan_buf[plan_len].last_of_run   = 1'b0;
                plan_len++;
            end
            add_turn(w.point_heading - heading_now);
            last_x = w.point_x;
            last_y = w.point_y;
            if (w.final_point) begin
                add_turn(goal_heading - heading_now);
                path_open = 1'b0;
            end
            if (plan_len > 0) plan_buf[plan_len-1].last_of_run = 1'b1;
            for (int i = 0; i < plan_len; i++) begin
                cmd_queue.insert(cmd_queue.size(), plan_buf[i]);
            end
        end
    endtask

    // Compares one accepted command with the oldest one awaited.
    task automatic check_command(input wtv_pkg::t_cmd_out got);
        wtv_pkg::t_cmd_out want;
        if (cmd_queue.size() == 0) begin
            $error("command item with none awaited: %h", got);
            fail_count++;
        end else begin
            want = cmd_queue.pop_front();
            if (got.cmd_kind !== want.cmd_kind) begin
                $error("cmd_kind: expected %0d, actual %0d", want.cmd_kind, got.cmd_kind);
                fail_count++;
            end
            if (got.forward_speed !== want.forward_speed) begin
                $error("forward_speed: expected %0d, actual %0d",
                       want.forward_speed, got.forward_speed);
                fail_count++;
            end
            if (got.turn_rate !== want.turn_rate) begin
                $error("turn_rate: expected %0d, actual %0d",
                       want.turn_rate, got.turn_rate);
                fail_count++;
            end
            if (got.last_of_run !== want.last_of_run) begin
                $error("last_of_run: expected %0d, actual %0d",
                       want.last_of_run, got.last_of_run);
                fail_count++;
            end
        end
    endtask

    initial fail_count = 0;

    // Sample all three channels at each rising edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_time    = 16'd512;
            goal_heading = 16'd0;
            last_x       = '0;
            last_y       = '0;
            heading_now  = '0;
            path_open    = 1'b0;
            cmd_queue.delete();
        end else begin
            if (i_out_valid && i_out_ready) check_command(i_out_data);
            if (i_in_valid && i_in_ready) plan_waypoint(i_in_data);
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == wtv_pkg::REG_STEP_TIME) hold_time = i_cfg_data;
                else goal_heading = i_cfg_data;
            end
        end
    end

endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives paths of waypoints into the waypoint-to-velocity block under several
// register settings, with random gaps on the waypoint side and random stalls
// on the command side. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 300;
    localparam int RANDOM_ITEMS = 410;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    wtv_pkg::t_wp_in   i_in_data;
    logic              o_out_valid;
    logic              i_out_ready;
    wtv_pkg::t_cmd_out o_out_data;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic              i_cfg_index;
    logic [15:0]       i_cfg_data;
    int                fail_count;
    int                pending;
    int                cycles;
    int                results_seen;
    logic [15:0]       last_heading;

    waypoint_to_velocity_commands dut (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .i_in_data,
        .o_out_valid, .i_out_ready, .o_out_data,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data
    );

    wtv_checker checker_inst (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_ready(o_in_ready), .i_in_data,
        .i_out_valid(o_out_valid), .i_out_ready, .i_out_data(o_out_data),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Clock.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Cycle limit.
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 70);
    endfunction

    // Command side: random stalls, calm stretches, and one long hold-off.
    initial begin
        int stall;
        int calm;
        bit held;
        stall = 0;
        calm = 0;
        held = 0;
        results_seen = 0;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) results_seen++;
            if (!held && results_seen >= 120) begin
                held = 1;
                stall = 3000;
            end
            if (calm > 0) calm--;
            else if ($urandom_range(0, 299) == 0) calm = $urandom_range(50, 200);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                stall--;
            end else begin
                i_out_ready <= 1'b1;
                if (calm == 0) stall = pick_gap();
            end
        end
    end

    function automatic wtv_pkg::t_wp_in make_wp(input int x, input int y, input int h,
                                                input bit fin);
        wtv_pkg::t_wp_in w;
        w.point_x       = x[19:0];
        w.point_y       = y[19:0];
        w.point_heading = h[15:0];
        w.final_point   = fin;
        return w;
    endfunction

    // Offers one item and holds it until accepted, then maybe leaves a gap.
    task automatic send_wp(input wtv_pkg::t_wp_in w);
        int gap;
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        last_heading = w.point_heading;
        do @(posedge i_clk); while (!o_in_ready);
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Lets all awaited commands come and the block settle.
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [15:0] st, input logic [15:0] goal);
        drain();
        write_reg(wtv_pkg::REG_STEP_TIME, st);
        write_reg(wtv_pkg::REG_GOAL, goal);
    endtask

    function automatic int clamp_pos(input int v);
        if (v > 524287) return 524287;
        if (v < -524288) return -524288;
        return v;
    endfunction

    // Random paths: mostly short hops, some repeats, jumps and extremes.
    task automatic run_paths(input int n);
        int sent;
        int len;
        int x;
        int y;
        int h;
        int r;
        sent = 0;
        x = $urandom_range(0, 20000) - 10000;
        y = $urandom_range(0, 20000) - 10000;
        while (sent < n) begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++) begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    x = clamp_pos(x + $urandom_range(0, 8000) - 4000);
                    y = clamp_pos(y + $urandom_range(0, 8000) - 4000);
                end else if (r < 88) begin
                    if (r >= 75) begin
                        x = $urandom_range(0, 1048575) - 524288;
                        y = $urandom_range(0, 1048575) - 524288;
                    end
                end else begin
                    x = $urandom_range(0, 1) ? 524287 : -524288;
                    y = $urandom_range(0, 1) ? 524287 : -524288;
                end
                r = $urandom_range(0, 99);
                if (r < 20) h = $signed(last_heading);
                else if (r < 28) h = $urandom_range(0, 1) ? 32767 : -32768;
                else h = $urandom_range(0, 65535) - 32768;
                send_wp(make_wp(x, y, h, i == len - 1));
                sent++;
            end
        end
    endtask

    // Stimulus and verdict.
    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = wtv_pkg::REG_STEP_TIME;
        i_cfg_data  = '0;
        last_heading = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_reg(wtv_pkg::REG_STEP_TIME, 16'd256);
        write_reg(wtv_pkg::REG_GOAL, 16'h4000);

        // Directed: single-point path, turn in place, half turns, extremes.
        send_wp(make_wp(100, 200, 0, 1));
        send_wp(make_wp(0, 0, 0, 0));
        send_wp(make_wp(0, 0, 16384, 0));
        send_wp(make_wp(0, 0, 16384, 0));
        send_wp(make_wp(0, 0, -32768, 0));
        send_wp(make_wp(524287, 524287, 32767, 0));
        send_wp(make_wp(-524288, -524288, -32768, 0));
        send_wp(make_wp(-524288, 524287, 0, 0));
        send_wp(make_wp(524287, -524288, 12345, 0));
        send_wp(make_wp(524287, 0, 0, 0));
        send_wp(make_wp(-524288, 0, 0, 0));
        send_wp(make_wp(0, 1, 0, 0));
        send_wp(make_wp(1, 1, 16384, 1));
        send_wp(make_wp(5, 5, 16384, 0));
        send_wp(make_wp(5, 5, 16384, 1));
        send_wp(make_wp(7, 9, -1, 0));
        send_wp(make_wp(7, 9, 1, 1));

        // Saturated speeds and full-range turns with the shortest hold time.
        set_regs(16'd1, 16'h8000);
        send_wp(make_wp(-524288, -524288, 0, 0));
        send_wp(make_wp(524287, 524287, -32768, 0));
        send_wp(make_wp(0, 0, 32767, 1));
        run_paths(RANDOM_ITEMS / 5);

        set_regs(16'd65535, 16'h7FFF);
        run_paths(RANDOM_ITEMS / 5);

        // Zero hold time acts as one.
        set_regs(16'd0, 16'd0);
        run_paths(RANDOM_ITEMS / 5);

        set_regs(16'd37, 16'($urandom_range(0, 65535)));
        run_paths(RANDOM_ITEMS / 5);

        set_regs(16'($urandom_range(1, 65535)), 16'($urandom_range(0, 65535)));
        run_paths(RANDOM_ITEMS / 5);

        drain();
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
